// File: rtl/lbs_pkg.sv
// Shared types and constants for the LED blink sequencer.
// No dependencies; imported by lbs_engine and led_blink_sequencer_core.
package lbs_pkg;

    // Operation codes carried by an input beat
    typedef enum logic [2:0] {
        OP_TICK       = 3'd0,
        OP_BURST      = 3'd1,
        OP_CONTINUOUS = 3'd2,
        OP_STOP       = 3'd3,
        OP_SHOW_ERROR = 3'd4
    } op_t;

    // Error display phase, one-hot
    typedef enum logic [2:0] {
        PH_ON  = 3'b001,
        PH_OFF = 3'b010,
        PH_GAP = 3'b100
    } err_phase_t;

    // Error display timing in milliseconds
    localparam logic [15:0] ERR_ONE_MS  = 16'd500;
    localparam logic [15:0] ERR_ZERO_MS = 16'd100;
    localparam logic [15:0] ERR_OFF_MS  = 16'd200;
    localparam logic [15:0] ERR_GAP_MS  = 16'd800;

    // Status produced by one beat, after its update
    typedef struct packed {
        logic       lit;
        logic       blinking;
        logic [7:0] burst_left;
        logic       err;
    } lbs_status_t;

    // Position of the most significant set bit, zero when none
    function automatic logic [2:0] top_bit(input logic [7:0] code);
        logic [2:0] p;
        p = 3'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (code[i])
            begin
                p = 3'(i);
            end
        end
        return p;
    endfunction

endpackage

// File: rtl/lbs_engine.sv
// Sequencer state and its combinational update for one registered input beat.
// Depends on lbs_pkg.
module lbs_engine
    import lbs_pkg::*;
#(
    parameter int TIME_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [2:0]         operation,
    input  logic [7:0]         blink_count,
    input  logic [15:0]        on_ms,
    input  logic [15:0]        off_ms,
    input  logic [7:0]         error_value,
    output lbs_status_t        status_next
);

    localparam int CW = (TIME_BITS > 16) ? TIME_BITS : 16;
    localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};

    logic                 lit_reg, lit_next;
    logic [TIME_BITS-1:0] elapsed_reg, elapsed_next;
    logic [7:0]           burst_left_reg, burst_left_next;
    logic                 repeat_on_reg, repeat_on_next;
    logic [15:0]          cur_on_reg, cur_on_next;
    logic [15:0]          cur_off_reg, cur_off_next;
    logic [15:0]          rep_on_reg, rep_on_next;
    logic [15:0]          rep_off_reg, rep_off_next;
    logic                 err_active_reg, err_active_next;
    logic [7:0]           err_code_reg, err_code_next;
    logic [2:0]           err_bit_pos_reg, err_bit_pos_next;
    err_phase_t           err_phase_reg, err_phase_next;

    logic [TIME_BITS-1:0] el_inc;
    logic [CW-1:0]        el_wide;
    logic [15:0]          wait_ms;
    logic [15:0]          off_eff;
    logic [15:0]          err_on_ms;
    logic [TIME_BITS-1:0] off_sat;

    // Update the state for the beat in the input register
    always_comb
    begin
        lit_next         = lit_reg;
        elapsed_next     = elapsed_reg;
        burst_left_next  = burst_left_reg;
        repeat_on_next   = repeat_on_reg;
        cur_on_next      = cur_on_reg;
        cur_off_next     = cur_off_reg;
        rep_on_next      = rep_on_reg;
        rep_off_next     = rep_off_reg;
        err_active_next  = err_active_reg;
        err_code_next    = err_code_reg;
        err_bit_pos_next = err_bit_pos_reg;
        err_phase_next   = err_phase_reg;

        el_inc    = (elapsed_reg == TMAX) ? elapsed_reg : elapsed_reg + 1'b1;
        el_wide   = CW'(el_inc);
        wait_ms   = lit_reg ? cur_on_reg : cur_off_reg;
        off_eff   = (off_ms != 16'd0) ? off_ms : on_ms;
        off_sat   = (CW'(off_eff) > CW'(TMAX)) ? TMAX : TIME_BITS'(CW'(off_eff));
        err_on_ms = err_code_reg[err_bit_pos_reg] ? ERR_ONE_MS : ERR_ZERO_MS;

        if (operation == OP_TICK)
        begin
            elapsed_next = el_inc;
            if (err_active_reg)
            begin
                // Walk the error code bit by bit
                unique case (err_phase_reg)
                    PH_ON:
                    begin
                        if (el_wide >= CW'(err_on_ms))
                        begin
                            lit_next       = 1'b0;
                            err_phase_next = PH_OFF;
                            elapsed_next   = '0;
                        end
                    end
                    PH_OFF:
                    begin
                        if (el_wide >= CW'(ERR_OFF_MS))
                        begin
                            elapsed_next = '0;
                            if (err_bit_pos_reg == 3'd0)
                            begin
                                err_phase_next = PH_GAP;
                            end
                            else
                            begin
                                err_bit_pos_next = err_bit_pos_reg - 3'd1;
                                err_phase_next   = PH_ON;
                                lit_next         = 1'b1;
                            end
                        end
                    end
                    PH_GAP:
                    begin
                        if (el_wide >= CW'(ERR_GAP_MS))
                        begin
                            elapsed_next = '0;
                            if (err_code_reg != 8'd0)
                            begin
                                err_bit_pos_next = top_bit(err_code_reg);
                                err_phase_next   = PH_ON;
                                lit_next         = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        err_phase_next = err_phase_reg;
                    end
                endcase
            end
            else if ((burst_left_reg != 8'd0 || repeat_on_reg) && el_wide >= CW'(wait_ms))
            begin
                // Toggle the LED and count a blink on each change to off
                elapsed_next = TIME_BITS'(el_wide - CW'(wait_ms));
                lit_next     = !lit_reg;
                if (lit_reg && burst_left_reg != 8'd0)
                begin
                    burst_left_next = burst_left_reg - 8'd1;
                    if (burst_left_reg == 8'd1 && repeat_on_reg)
                    begin
                        cur_on_next  = rep_on_reg;
                        cur_off_next = rep_off_reg;
                    end
                end
            end
        end
        else if (!err_active_reg)
        begin
            unique case (operation)
                OP_BURST, OP_CONTINUOUS:
                begin
                    burst_left_next = (operation == OP_BURST) ? blink_count : 8'd0;
                    cur_on_next     = on_ms;
                    cur_off_next    = off_eff;
                    elapsed_next    = lit_reg ? '0 : off_sat;
                    lit_next        = 1'b0;
                    if (operation == OP_CONTINUOUS)
                    begin
                        repeat_on_next = 1'b1;
                        rep_on_next    = on_ms;
                        rep_off_next   = off_eff;
                    end
                end
                OP_STOP:
                begin
                    burst_left_next = 8'd0;
                    repeat_on_next  = 1'b0;
                    lit_next        = 1'b0;
                end
                OP_SHOW_ERROR:
                begin
                    err_active_next = 1'b1;
                    err_code_next   = error_value;
                    burst_left_next = 8'd0;
                    repeat_on_next  = 1'b0;
                    elapsed_next    = '0;
                    if (error_value != 8'd0)
                    begin
                        err_bit_pos_next = top_bit(error_value);
                        err_phase_next   = PH_ON;
                        lit_next         = 1'b1;
                    end
                    else
                    begin
                        err_bit_pos_next = 3'd0;
                        err_phase_next   = PH_GAP;
                        lit_next         = 1'b0;
                    end
                end
                default:
                begin
                    lit_next = lit_reg;
                end
            endcase
        end

        status_next.lit        = lit_next;
        status_next.blinking   = err_active_next || (burst_left_next != 8'd0)
                                 || repeat_on_next;
        status_next.burst_left = burst_left_next;
        status_next.err        = err_active_next;
    end

    // Hold the state, advance on each beat taken from the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lit_reg         <= 1'b0;
            elapsed_reg     <= '0;
            burst_left_reg  <= 8'd0;
            repeat_on_reg   <= 1'b0;
            cur_on_reg      <= 16'd0;
            cur_off_reg     <= 16'd0;
            rep_on_reg      <= 16'd0;
            rep_off_reg     <= 16'd0;
            err_active_reg  <= 1'b0;
            err_code_reg    <= 8'd0;
            err_bit_pos_reg <= 3'd0;
            err_phase_reg   <= PH_ON;
        end
        else if (step)
        begin
            lit_reg         <= lit_next;
            elapsed_reg     <= elapsed_next;
            burst_left_reg  <= burst_left_next;
            repeat_on_reg   <= repeat_on_next;
            cur_on_reg      <= cur_on_next;
            cur_off_reg     <= cur_off_next;
            rep_on_reg      <= rep_on_next;
            rep_off_reg     <= rep_off_next;
            err_active_reg  <= err_active_next;
            err_code_reg    <= err_code_next;
            err_bit_pos_reg <= err_bit_pos_next;
            err_phase_reg   <= err_phase_next;
        end
    end

endmodule

// File: rtl/led_blink_sequencer_core.sv
// LED blink sequencer: an accepted input beat passes through the input register, then the
// result register, to its result beat; throughput one beat per cycle while out_stall
// is low. The elapsed counter width is TIME_BITS; the sequencer update is combinational.
// Reset (rst_n, asynchronous, active low) clears the sequencer state, empties both registers and
// sets active_level to 1.
// Depends on lbs_pkg and lbs_engine.
module led_blink_sequencer_core
    import lbs_pkg::*;
#(
    parameter int TIME_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  operation,
    input  logic [7:0]  blink_count,
    input  logic [15:0] on_ms,
    input  logic [15:0] off_ms,
    input  logic [7:0]  error_value,
    // Result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic        led_lit,
    output logic        pin_level,
    output logic        is_blinking,
    output logic [7:0]  blinks_remaining,
    output logic        in_error_mode,
    // Configuration channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);

    logic        in_valid_reg;
    logic [2:0]  op_reg;
    logic [7:0]  count_reg;
    logic [15:0] on_reg;
    logic [15:0] off_reg;
    logic [7:0]  code_reg;

    logic        out_valid_reg;
    lbs_status_t status_reg;
    lbs_status_t status_next;
    logic        active_level_reg;

    logic        advance;
    logic        accept;

    // Move a beat on when the result register is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= operation;
            count_reg <= blink_count;
            on_reg    <= on_ms;
            off_reg   <= off_ms;
            code_reg  <= error_value;
        end
    end

    lbs_engine #(
        .TIME_BITS (TIME_BITS)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .operation   (op_reg),
        .blink_count (count_reg),
        .on_ms       (on_reg),
        .off_ms      (off_reg),
        .error_value (code_reg),
        .status_next (status_next)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg <= status_next;
        end
    end

    // Active level register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_level_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            active_level_reg <= cfg_data;
        end
    end

    // Drive the result beat
    assign out_valid        = out_valid_reg;
    assign led_lit          = status_reg.lit;
    assign pin_level        = (status_reg.lit == active_level_reg);
    assign is_blinking      = status_reg.blinking;
    assign blinks_remaining = status_reg.burst_left;
    assign in_error_mode    = status_reg.err;

endmodule
